// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PPU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ppu_pkg.sv -----
package ppu_pkg;

  // Pool size default and fixed field widths.
  localparam int unsigned POOL_SIZE_DEF = 64;
  localparam int unsigned VEC_W         = 48;
  localparam int unsigned CNT_W         = 7;

  // Command codes on func_i.
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_EMIT   = 2'd1;
  localparam logic [1:0] FUNC_RESET  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_GRAV_X = 2'd0;
  localparam logic [1:0] REG_GRAV_Y = 2'd1;
  localparam logic [1:0] REG_GRAV_Z = 2'd2;

  // Gravity reset values, signed Q8.8.
  localparam logic signed [15:0] GRAV_X_RST = 16'sd0;
  localparam logic signed [15:0] GRAV_Y_RST = -16'sd2509;
  localparam logic signed [15:0] GRAV_Z_RST = 16'sd0;

  // One word of slot memory.
  typedef struct packed {
    logic [VEC_W-1:0]   pos;
    logic [VEC_W-1:0]   pbeg;
    logic [VEC_W-1:0]   pend;
    logic [VEC_W-1:0]   vel;
    logic signed [15:0] rot;
    logic [15:0]        life;
    logic signed [16:0] rem;
    logic               grav;
    logic               path;
  } slot_t;

  // Signed Q8.8 component j (0 is x) of a packed vector.
  function automatic logic signed [15:0] comp(input logic [VEC_W-1:0] v, input int j);
    comp = v[VEC_W-1-16*j -: 16];
  endfunction

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

// ----- hdl/ppu_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module ppu_ram #(
  parameter int unsigned WIDTH = ppu_pkg::VEC_W,
  parameter int unsigned DEPTH = ppu_pkg::POOL_SIZE_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/ppu_div.sv -----
// Radix-4 restoring divider for the life fraction: quot = (dividend << 16) / divisor.
// The caller guarantees dividend < divisor, so the quotient fits 16 bits.
module ppu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic [15:0] rem_q, dvs_q, quot_q;
  logic [15:0] rem_d, quot_d;
  logic [2:0]  cnt_q;
  logic        run_q, done_q;

  // Two quotient bits per cycle.
  always_comb begin
    logic [16:0] r2;
    rem_d  = rem_q;
    quot_d = quot_q;
    for (int k = 0; k < 2; k++) begin
      r2 = {rem_d, 1'b0};
      if (r2 >= {1'b0, dvs_q}) begin
        r2     = r2 - {1'b0, dvs_q};
        quot_d = {quot_d[14:0], 1'b1};
      end else begin
        quot_d = {quot_d[14:0], 1'b0};
      end
      rem_d = r2[15:0];
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 3'd7;
      end else if (run_q) begin
        cnt_q <= cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- hdl/particle_pool_update.sv -----
// Particle pool update engine. Start an item with start while busy is low;
// results appear on the result ports for one cycle each with strobe_o, and the
// receiver must take them as they come. A reset-pool or unused command returns
// its single result in the cycle after acceptance and never raises busy. An
// emit passes through its single emit state, which writes the new slot and
// registers its result. A tick scans every slot in turn; each active slot goes
// through the load, update, multiply and write-back states, and one whose life
// fraction needs the shared 2-bit-per-cycle divider also waits in the divide
// state. All slot data lives in one RAM with a registered read; each slot is
// read, updated and written back before the next is read. The active bits sit
// in flip-flops and are cleared by reset, so no clearing pass is needed.
module particle_pool_update #(
  parameter int unsigned POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [15:0]        delta_time_i,
  input  logic [47:0]        spawn_position_i,
  input  logic [47:0]        path_begin_i,
  input  logic [47:0]        path_end_i,
  input  logic [47:0]        initial_velocity_i,
  input  logic [47:0]        velocity_spread_i,
  input  logic signed [15:0] base_rotation_i,
  input  logic [15:0]        life_time_i,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        random_velocity_i,
  input  logic [15:0]        random_rotation_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               strobe_o,
  output logic               valid_res_o,
  output logic [5:0]         slot_o,
  output logic [47:0]        position_o,
  output logic signed [15:0] rotation_o,
  output logic [15:0]        life_fraction_o,
  output logic [6:0]         active_count_o,
  output logic               last_o
);

  localparam int unsigned SW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CW    = ppu_pkg::CNT_W;
  localparam int unsigned WORD  = $bits(ppu_pkg::slot_t);
  localparam logic [SW-1:0] LAST_IDX = SW'(POOL_SIZE - 1);
  // Reciprocal of 10 for the rotation step, exact for dividends below 2^22.
  localparam logic [19:0] RECIP10 = 20'd838861;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_LOAD = 9'b000001000,
    S_UPD  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_MUL  = 9'b001000000,
    S_WB   = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [5:0]         slot;
    logic [47:0]        pos;
    logic signed [15:0] rot;
    logic [15:0]        frac;
  } res_t;

  // Control state.
  state_e              state_q;
  logic [SW-1:0]       idx_q, next_slot_q;
  logic [POOL_SIZE-1:0] act_q, exp_q;
  logic [CW-1:0]       live_q, exp_cnt_q, exp_acc_q, final_cnt_q;
  logic signed [15:0]  grav_q [3];
  logic                out_stb_q, hold_v_q;
  logic                fin_q;

  // Payload registers.
  res_t                out_q, hold_q;
  logic [CW-1:0]       out_cnt_q;
  logic                out_last_q;
  logic [15:0]         dt_q;
  logic [16:0]         rot_inc_q;
  ppu_pkg::slot_t      w_q;
  logic                w_old_exp_q;
  logic [15:0]         fr_q;
  logic signed [34:0]  prod_q [3];
  logic [47:0]         e_spawn_q, e_beg_q, e_end_q, e_vel_q, e_spr_q;
  logic signed [15:0]  e_rot_q;
  logic [15:0]         e_life_q, e_rv_q, e_rr_q;
  logic [1:0]          e_mode_q;

  logic                accept;
  logic                ram_we, ram_re;
  logic [SW-1:0]       ram_waddr;
  ppu_pkg::slot_t      ram_wdata, ram_rdata;
  logic                div_start, div_done;
  logic [15:0]         div_quot;

  // The cycle that commits the counts of a tick still counts as busy.
  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE) || fin_q;
  assign cfg_ready_o = 1'b1;

  ppu_ram #(
    .WIDTH (WORD),
    .DEPTH (POOL_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  ppu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (w_q.rem[15:0]),
    .divisor_i  (w_q.life),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Load step: gravity on the velocity and the new remaining life.
  ppu_pkg::slot_t ld_word;
  always_comb begin
    logic signed [32:0] gp;
    logic signed [15:0] vin;
    logic signed [17:0] rs;
    ld_word = ram_rdata;
    for (int j = 0; j < 3; j++) begin
      vin = ppu_pkg::comp(ram_rdata.vel, j);
      gp  = grav_q[j] * $signed({1'b0, dt_q});
      if (ram_rdata.grav) begin
        ld_word.vel[47-16*j -: 16] =
          ppu_pkg::sat16(40'(vin) + ((40'(gp) + 40'sd128) >>> 8));
      end
    end
    rs = 18'(ram_rdata.rem) - $signed({2'b00, dt_q});
    if (rs < -18'sd65536) begin
      ld_word.rem = -17'sd65536;
    end else begin
      ld_word.rem = rs[16:0];
    end
  end

  // Fraction cases that need no division.
  logic rem_le0, rem_full;
  assign rem_le0  = (w_q.rem <= 17'sd0) || (w_q.life == 16'd0);
  assign rem_full = (w_q.rem[15:0] >= w_q.life);
  assign div_start = (state_q == S_UPD) && !rem_le0 && !rem_full;

  // Write-back step: position, rotation and the result of this slot.
  ppu_pkg::slot_t wb_word;
  res_t           wb_res;
  logic           wb_act, wb_exp;
  always_comb begin
    logic signed [15:0] base;
    wb_word = w_q;
    for (int j = 0; j < 3; j++) begin
      if (w_q.path) begin
        base = ppu_pkg::comp(w_q.pbeg, j);
        wb_word.pos[47-16*j -: 16] =
          ppu_pkg::sat16(40'(base) + ((40'(prod_q[j]) + 40'sd32768) >>> 16));
      end else begin
        base = ppu_pkg::comp(w_q.pos, j);
        wb_word.pos[47-16*j -: 16] =
          ppu_pkg::sat16(40'(base) + ((40'(prod_q[j]) + 40'sd128) >>> 8));
      end
    end
    wb_word.rot  = ppu_pkg::sat16(40'(w_q.rot) + 40'(rot_inc_q));
    wb_act       = !w_old_exp_q;
    wb_exp       = wb_act && (w_q.rem <= 17'sd0);
    wb_res.valid = wb_act;
    wb_res.slot  = 6'(idx_q);
    wb_res.pos   = wb_word.pos;
    wb_res.rot   = wb_word.rot;
    wb_res.frac  = fr_q;
  end

  // Emit step: perturbed velocity and rotation of the new particle.
  ppu_pkg::slot_t em_word;
  logic [CW-1:0]  em_cnt;
  logic           em_was_exp;
  always_comb begin
    logic signed [16:0] rv, rr;
    logic signed [32:0] sp;
    logic signed [15:0] iv;
    rv = $signed({1'b0, e_rv_q}) - 17'sd32768;
    rr = $signed({1'b0, e_rr_q}) - 17'sd32768;
    em_word.pos  = e_spawn_q;
    em_word.pbeg = e_beg_q;
    em_word.pend = e_end_q;
    em_word.vel  = '0;
    for (int j = 0; j < 3; j++) begin
      iv = ppu_pkg::comp(e_vel_q, j);
      sp = ppu_pkg::comp(e_spr_q, j) * rv;
      em_word.vel[47-16*j -: 16] =
        ppu_pkg::sat16(40'(iv) + ((40'(sp) + 40'sd32768) >>> 16));
    end
    em_word.rot  = ppu_pkg::sat16(40'(e_rot_q) + ((40'(rr) + 40'sd4) >>> 3));
    em_word.life = e_life_q;
    em_word.rem  = $signed({1'b0, e_life_q});
    em_word.grav = e_mode_q[0];
    em_word.path = e_mode_q[1];
    em_was_exp   = act_q[next_slot_q] && exp_q[next_slot_q];
    em_cnt       = live_q + CW'(!act_q[next_slot_q]);
  end

  // Memory port control.
  always_comb begin
    ram_re    = (state_q == S_SCAN) && act_q[idx_q];
    ram_we    = (state_q == S_WB) || (state_q == S_EMIT);
    ram_waddr = (state_q == S_EMIT) ? next_slot_q : idx_q;
    ram_wdata = (state_q == S_EMIT) ? em_word : wb_word;
  end

  // Control registers and sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      next_slot_q <= LAST_IDX;
      act_q       <= '0;
      exp_q       <= '0;
      live_q      <= '0;
      exp_cnt_q   <= '0;
      exp_acc_q   <= '0;
      final_cnt_q <= '0;
      grav_q[0]   <= ppu_pkg::GRAV_X_RST;
      grav_q[1]   <= ppu_pkg::GRAV_Y_RST;
      grav_q[2]   <= ppu_pkg::GRAV_Z_RST;
      out_stb_q   <= 1'b0;
      hold_v_q    <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      out_stb_q <= 1'b0;
      fin_q     <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ppu_pkg::REG_GRAV_X: grav_q[0] <= cfg_data_i;
          ppu_pkg::REG_GRAV_Y: grav_q[1] <= cfg_data_i;
          ppu_pkg::REG_GRAV_Z: grav_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (func_i)
              ppu_pkg::FUNC_TICK: state_q <= S_PREP;
              ppu_pkg::FUNC_EMIT: state_q <= S_EMIT;
              ppu_pkg::FUNC_RESET: begin
                act_q       <= '0;
                exp_q       <= '0;
                live_q      <= '0;
                exp_cnt_q   <= '0;
                next_slot_q <= LAST_IDX;
                out_stb_q   <= 1'b1;
              end
              default: out_stb_q <= 1'b1;
            endcase
          end
        end
        S_PREP: begin
          idx_q       <= '0;
          exp_acc_q   <= '0;
          final_cnt_q <= live_q - exp_cnt_q;
          state_q     <= S_SCAN;
        end
        S_SCAN: begin
          if (act_q[idx_q]) begin
            state_q <= S_LOAD;
          end else if (idx_q == LAST_IDX) begin
            fin_q   <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end
        S_LOAD: state_q <= S_UPD;
        S_UPD:  state_q <= div_start ? S_DIV : S_MUL;
        S_DIV:  if (div_done) state_q <= S_MUL;
        S_MUL:  state_q <= S_WB;
        S_WB: begin
          act_q[idx_q] <= wb_act;
          exp_q[idx_q] <= wb_exp;
          exp_acc_q    <= exp_acc_q + CW'(wb_exp);
          hold_v_q     <= 1'b1;
          out_stb_q    <= hold_v_q;
          if (idx_q != LAST_IDX) begin
            idx_q <= idx_q + SW'(1);
          end
          state_q <= (idx_q == LAST_IDX) ? S_IDLE : S_SCAN;
          fin_q   <= (idx_q == LAST_IDX);
        end
        S_EMIT: begin
          act_q[next_slot_q] <= 1'b1;
          exp_q[next_slot_q] <= (e_life_q == 16'd0);
          live_q      <= em_cnt;
          exp_cnt_q   <= exp_cnt_q - CW'(em_was_exp) + CW'(e_life_q == 16'd0);
          next_slot_q <= (next_slot_q == '0) ? LAST_IDX : next_slot_q - SW'(1);
          out_stb_q   <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // End of a tick: flush the held result and commit the counts.
      if (fin_q) begin
        out_stb_q <= 1'b1;
        hold_v_q  <= 1'b0;
        live_q    <= final_cnt_q;
        exp_cnt_q <= exp_acc_q;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q      <= delta_time_i;
      e_spawn_q <= spawn_position_i;
      e_beg_q   <= path_begin_i;
      e_end_q   <= path_end_i;
      e_vel_q   <= initial_velocity_i;
      e_spr_q   <= velocity_spread_i;
      e_rot_q   <= base_rotation_i;
      e_life_q  <= life_time_i;
      e_mode_q  <= mode_i;
      e_rv_q    <= random_velocity_i;
      e_rr_q    <= random_rotation_i;
      out_q     <= '0;
      out_last_q <= 1'b1;
      out_cnt_q <= (func_i == ppu_pkg::FUNC_RESET) ? '0 : live_q;
    end
    unique case (state_q)
      S_PREP: begin
        rot_inc_q <= 17'((41'({dt_q, 4'b0000} + 20'd5) * 41'(RECIP10)) >> 23);
      end
      S_LOAD: begin
        w_q         <= ld_word;
        w_old_exp_q <= (ram_rdata.rem <= 17'sd0);
      end
      S_UPD: begin
        if (rem_le0) begin
          fr_q <= '0;
        end else if (rem_full) begin
          fr_q <= 16'hffff;
        end
      end
      S_DIV: begin
        if (div_done) fr_q <= div_quot;
      end
      S_MUL: begin
        for (int j = 0; j < 3; j++) begin
          if (w_q.path) begin
            prod_q[j] <= (18'(ppu_pkg::comp(w_q.pend, j)) - 18'(ppu_pkg::comp(w_q.pbeg, j)))
                         * $signed({1'b0, 17'(17'h10000 - {1'b0, fr_q})});
          end else begin
            prod_q[j] <= ppu_pkg::comp(w_q.vel, j) * $signed({1'b0, dt_q});
          end
        end
      end
      S_WB: begin
        hold_q <= wb_res;
        if (hold_v_q) begin
          out_q      <= hold_q;
          out_last_q <= 1'b0;
          out_cnt_q  <= final_cnt_q;
        end
      end
      S_EMIT: begin
        out_q.valid <= 1'b1;
        out_q.slot  <= 6'(next_slot_q);
        out_q.pos   <= em_word.pos;
        out_q.rot   <= em_word.rot;
        out_q.frac  <= (e_life_q == 16'd0) ? 16'd0 : 16'hffff;
        out_last_q  <= 1'b1;
        out_cnt_q   <= em_cnt;
      end
      default: ;
    endcase
    // Final result of a tick: the held slot, or an all-zero result.
    if (fin_q) begin
      out_q      <= hold_v_q ? hold_q : '0;
      out_last_q <= 1'b1;
      out_cnt_q  <= final_cnt_q;
    end
  end

  // Result ports.
  assign strobe_o        = out_stb_q;
  assign valid_res_o     = out_q.valid;
  assign slot_o          = out_q.slot;
  assign position_o      = out_q.pos;
  assign rotation_o      = out_q.rot;
  assign life_fraction_o = out_q.frac;
  assign active_count_o  = out_cnt_q;
  assign last_o          = out_last_q;

endmodule

// ----- hdl/ppu_checker.sv -----
`include "assert_macros.svh"

// Port-level checks on the pool update engine.
module ppu_checker #(
  parameter int unsigned POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] func_i,
  input logic       strobe_o,
  input logic       valid_res_o,
  input logic       last_o,
  input logic [6:0] active_count_o
);

  // The reported count never exceeds the pool.
  `PPU_ASSERT_IMP(a_cnt_bound, strobe_o, active_count_o <= 7'(POOL_SIZE), "count above pool size")

  // An active particle in a result implies a nonzero count.
  `PPU_ASSERT_IMP(a_valid_cnt, strobe_o && valid_res_o, active_count_o != 7'd0, "active slot with zero count")

  // An accepted emit keeps the engine busy for its write cycle.
  `PPU_ASSERT_NXT(a_emit_busy, start && !busy && func_i == ppu_pkg::FUNC_EMIT, busy, "emit not busy")

  // A pool reset answers at once with a single empty result.
  `PPU_ASSERT_NXT(a_reset_res, start && !busy && func_i == ppu_pkg::FUNC_RESET, strobe_o && last_o && active_count_o == 7'd0, "bad reset result")

endmodule

bind particle_pool_update ppu_checker #(.POOL_SIZE(POOL_SIZE)) u_ppu_checker (.*);
